// ===== src/cutrp_pkg.sv =====
// ----------------------------------------------------------------------------
// cutrp_pkg: shared types and constants for the USB tx record parser
// Input and result item layouts, status byte bit positions, id shifts.
// ----------------------------------------------------------------------------
package cutrp_pkg;

  localparam int MAX_DATA_BYTES = 8;

  // status byte layout
  localparam int STATUS_RTR_BIT = 4;
  localparam int STATUS_EXT_BIT = 5;

  // id word alignment
  localparam int EXT_ID_SHIFT = 3;
  localparam int STD_ID_SHIFT = 5;

  localparam int EXT_ID_BYTES = 4;
  localparam int STD_ID_BYTES = 2;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic        frame_valid;
    logic [28:0] frame_id;
    logic        frame_extended;
    logic        frame_remote;
    logic [3:0]  frame_length;
    logic [63:0] frame_data;
    logic        message_done;
    logic [7:0]  frames_decoded;
    logic        message_too_short;
  } out_item_t;

endpackage

// ===== src/can_usb_tx_record_parser.sv =====
// ----------------------------------------------------------------------------
// can_usb_tx_record_parser: byte-serial decoder for host tx messages
// Walks header, status, id and data bytes; emits a frame per decoded record.
// ----------------------------------------------------------------------------
// One byte is taken every clock cycle unless the input stalls. Each byte
// updates the parse state through a single stage of logic, and any frame or
// end-of-message summary it causes lands in the output register on the same
// edge. The input stalls only while a result sits in the output register and
// the sink holds out_stall; in that case the block resumes as soon as the
// result is taken. The frame cap may be written between messages and is kept
// across messages.
module can_usb_tx_record_parser
  import cutrp_pkg::*;
#(
  parameter int HEADER_BYTES = 2
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item,
  input  logic      cfg_we,
  input  logic [7:0] cfg_wdata
);

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_STATUS,
    PH_ID,
    PH_DATA
  } phase_t;

  localparam logic [1:0] HDR_LAST = 2'(HEADER_BYTES - 1);
  localparam logic [3:0] LEN_MAX  = 4'(MAX_DATA_BYTES);

  phase_t      phase_r, phase_nxt;
  logic [1:0]  bytes_seen_r, bytes_seen_nxt;
  logic [7:0]  rec_exp_r, rec_exp_nxt;
  logic [7:0]  frames_r, frames_nxt;
  logic [7:0]  status_r, status_nxt;
  logic [31:0] id_shift_r, id_shift_nxt;
  logic [2:0]  idx_r, idx_nxt;
  logic [63:0] data_r, data_nxt;
  logic        stopped_r, stopped_nxt;
  logic [7:0]  frame_cap_r;
  logic        out_valid_r;
  out_item_t   out_item_r, res;

  logic        in_fire;
  logic        emit, too_short;
  logic        ext, rtr;
  logic [3:0]  len;
  logic [3:0]  idx_inc;
  logic [3:0]  id_need;
  logic [7:0]  frames_cnt;
  logic [7:0]  b;

  assign in_stall  = out_valid_r & out_stall;
  assign in_fire   = in_valid & ~in_stall;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  assign b       = in_item.byte_value;
  assign ext     = status_r[STATUS_EXT_BIT];
  assign rtr     = status_r[STATUS_RTR_BIT];
  assign len     = (status_r[3:0] > LEN_MAX) ? LEN_MAX : status_r[3:0];
  assign idx_inc = {1'b0, idx_r} + 4'd1;
  assign id_need = ext ? 4'(EXT_ID_BYTES) : 4'(STD_ID_BYTES);

  always_comb begin
    phase_nxt      = phase_r;
    bytes_seen_nxt = bytes_seen_r;
    rec_exp_nxt    = rec_exp_r;
    frames_nxt     = frames_r;
    status_nxt     = status_r;
    id_shift_nxt   = id_shift_r;
    idx_nxt        = idx_r;
    data_nxt       = data_r;
    stopped_nxt    = stopped_r;
    emit           = 1'b0;
    too_short      = 1'b0;

    case (phase_r)
      PH_HEADER: begin
        if (bytes_seen_r == 2'd1) rec_exp_nxt = b;
        if (bytes_seen_r >= HDR_LAST) begin
          phase_nxt = PH_STATUS;
        end else begin
          too_short = 1'b1;
          if (bytes_seen_r != 2'd3) bytes_seen_nxt = bytes_seen_r + 2'd1;
        end
      end
      PH_STATUS: begin
        if (!stopped_r) begin
          if (frames_r >= rec_exp_r || frames_r >= frame_cap_r) begin
            stopped_nxt = 1'b1;
          end else begin
            status_nxt   = b;
            id_shift_nxt = '0;
            idx_nxt      = '0;
            data_nxt     = '0;
            phase_nxt    = PH_ID;
          end
        end
      end
      PH_ID: begin
        if (!stopped_r) begin
          id_shift_nxt = id_shift_r | (32'(b) << {idx_r[1:0], 3'b000});
          if (idx_inc >= id_need) begin
            idx_nxt = '0;
            if (rtr || len == 4'd0) emit = 1'b1;
            else phase_nxt = PH_DATA;
          end else begin
            idx_nxt = idx_inc[2:0];
          end
        end
      end
      PH_DATA: begin
        if (!stopped_r) begin
          data_nxt = data_r | (64'(b) << {idx_r, 3'b000});
          if (idx_inc >= len) emit = 1'b1;
          else idx_nxt = idx_inc[2:0];
        end
      end
      default: phase_nxt = PH_HEADER;
    endcase

    frames_cnt = emit ? frames_r + 8'd1 : frames_r;

    // result is built from the word that includes the current byte
    res = '0;
    if (emit) begin
      res.frame_valid    = 1'b1;
      res.frame_id       = ext ? id_shift_nxt[31:EXT_ID_SHIFT]
                               : {18'b0, id_shift_nxt[15:STD_ID_SHIFT]};
      res.frame_extended = ext;
      res.frame_remote   = rtr;
      res.frame_length   = len;
      res.frame_data     = rtr ? 64'd0 : data_nxt;
      frames_nxt         = frames_cnt;
      idx_nxt            = '0;
      phase_nxt          = PH_STATUS;
    end

    if (in_item.last_byte) begin
      res.message_done      = 1'b1;
      res.frames_decoded    = frames_cnt;
      res.message_too_short = too_short;
      phase_nxt      = PH_HEADER;
      bytes_seen_nxt = '0;
      rec_exp_nxt    = '0;
      frames_nxt     = '0;
      status_nxt     = '0;
      id_shift_nxt   = '0;
      idx_nxt        = '0;
      data_nxt       = '0;
      stopped_nxt    = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_HEADER;
      bytes_seen_r <= '0;
      rec_exp_r    <= '0;
      frames_r     <= '0;
      status_r     <= '0;
      id_shift_r   <= '0;
      idx_r        <= '0;
      data_r       <= '0;
      stopped_r    <= 1'b0;
      frame_cap_r  <= 8'd255;
      out_valid_r  <= 1'b0;
      out_item_r   <= '0;
    end else begin
      if (cfg_we) frame_cap_r <= cfg_wdata;
      if (in_fire) begin
        phase_r      <= phase_nxt;
        bytes_seen_r <= bytes_seen_nxt;
        rec_exp_r    <= rec_exp_nxt;
        frames_r     <= frames_nxt;
        status_r     <= status_nxt;
        id_shift_r   <= id_shift_nxt;
        idx_r        <= idx_nxt;
        data_r       <= data_nxt;
        stopped_r    <= stopped_nxt;
      end
      if (in_fire && (emit || in_item.last_byte)) begin
        out_valid_r <= 1'b1;
        out_item_r  <= res;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule

// ===== src/cutrp_checker.sv =====
// ----------------------------------------------------------------------------
// cutrp_checker: port-level checks for the USB tx record parser
// Watches the result channel and the input stall; bound to the parser module.
// ----------------------------------------------------------------------------
module cutrp_checker
  import cutrp_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_stall,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_item
);

  // a held result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("result changed while stalled");

  // every item carries a frame or a summary
  a_out_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_item.frame_valid || out_item.message_done)
    else $error("empty result item");

  // frame fields are clean when no frame, length clipped, remote has no data
  a_frame_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_item.frame_length <= 4'(MAX_DATA_BYTES))
      && (out_item.frame_valid || (out_item.frame_id == '0
          && out_item.frame_data == '0 && out_item.frame_length == '0
          && !out_item.frame_extended && !out_item.frame_remote))
      && (!out_item.frame_remote || out_item.frame_data == '0))
    else $error("bad frame fields");

  // summary fields only with message_done
  a_summary_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_item.message_done |->
      out_item.frames_decoded == '0 && !out_item.message_too_short)
    else $error("summary fields without message_done");

  // input stalls only behind a held result
  a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled with output free");

endmodule

bind can_usb_tx_record_parser cutrp_checker u_cutrp_checker (.*);

// ===== bench/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: testbench for can_usb_tx_record_parser
// Feeds host tx messages one byte at a time: first a fixed list of messages,
// then random ones, most of them well formed. Every taken byte runs through
// a local copy of the record decoder, and the frames and message summaries
// that come out of the block are checked against it in order.
// ----------------------------------------------------------------------------
module tb_top;
  import cutrp_pkg::*;

  localparam int HEADER_LEN   = 2;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int RANDOM_ITEMS = 420;
  localparam int HOLD_CYCLES  = 80;

  typedef enum logic [1:0] {PH_HEADER, PH_STATUS, PH_ID, PH_DATA} parse_phase_t;

  typedef struct packed {
    logic [7:0] b;
    logic       lst;
    logic       typed;
    out_item_t  want;
  } stim_row_t;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_item;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_item;
  logic      cfg_we;
  logic [7:0] cfg_wdata;

  // decoder copy
  parse_phase_t st_phase;
  logic [1:0]   st_hdr_count;
  logic [7:0]   st_records;
  logic [7:0]   st_frames;
  logic [7:0]   st_status;
  logic [31:0]  st_id;
  logic [3:0]   st_index;
  logic [63:0]  st_data;
  logic         st_stopped;
  logic [7:0]   frame_cap_cfg;

  out_item_t decoded_q[$];
  stim_row_t dir_rows[$];

  // typed expectation that rides along with the byte on the input
  logic      cur_typed;
  out_item_t cur_want;

  logic idle_on;
  logic hold_request;
  int   mismatches;
  int   live_count;
  int   items_taken;
  int   results_checked;
  int   cycle_count;

  can_usb_tx_record_parser #(.HEADER_BYTES(HEADER_LEN)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  function automatic logic [3:0] clip_len(input logic [7:0] s);
    return (s[3:0] > MAX_DATA_BYTES) ? 4'(MAX_DATA_BYTES) : s[3:0];
  endfunction

  function automatic void clear_message();
    st_phase     = PH_HEADER;
    st_hdr_count = '0;
    st_records   = '0;
    st_frames    = '0;
    st_status    = '0;
    st_id        = '0;
    st_index     = '0;
    st_data      = '0;
    st_stopped   = 1'b0;
  endfunction

  function automatic void parse_byte(input logic [7:0] b, input logic lst,
                                     output logic has, output out_item_t res);
    logic        emit;
    logic        short_hdr;
    logic        ext;
    logic        rtr;
    logic [31:0] id_word;
    res       = '0;
    emit      = 1'b0;
    short_hdr = 1'b0;
    ext       = st_status[STATUS_EXT_BIT];
    rtr       = st_status[STATUS_RTR_BIT];
    if (st_phase == PH_HEADER) begin
      if (st_hdr_count == 2'd1) st_records = b;
      if (st_hdr_count + 1 >= HEADER_LEN) begin
        st_phase = PH_STATUS;
      end else begin
        short_hdr = 1'b1;
        if (st_hdr_count < 2'd3) st_hdr_count = st_hdr_count + 2'd1;
      end
    end else if (st_stopped) begin
      // rest of the message is dropped
    end else if (st_phase == PH_STATUS) begin
      if (st_frames >= st_records || st_frames >= frame_cap_cfg) begin
        st_stopped = 1'b1;
      end else begin
        st_status = b;
        st_id     = '0;
        st_index  = '0;
        st_data   = '0;
        st_phase  = PH_ID;
      end
    end else if (st_phase == PH_ID) begin
      st_id    = st_id | ({24'h0, b} << (8 * st_index[1:0]));
      st_index = st_index + 4'd1;
      if (st_index >= (ext ? EXT_ID_BYTES : STD_ID_BYTES)) begin
        st_index = '0;
        if (rtr || clip_len(st_status) == 0) emit = 1'b1;
        else st_phase = PH_DATA;
      end
    end else begin
      st_data  = st_data | ({56'h0, b} << (8 * st_index[2:0]));
      st_index = st_index + 4'd1;
      if (st_index >= clip_len(st_status)) emit = 1'b1;
    end

    if (emit) begin
      id_word = ext ? (st_id >> EXT_ID_SHIFT) : ({16'h0, st_id[15:0]} >> STD_ID_SHIFT);
      res.frame_valid    = 1'b1;
      res.frame_id       = id_word[28:0];
      res.frame_extended = ext;
      res.frame_remote   = rtr;
      res.frame_length   = clip_len(st_status);
      res.frame_data     = rtr ? 64'h0 : st_data;
      st_frames = st_frames + 8'd1;
      st_index  = '0;
      st_phase  = PH_STATUS;
    end

    if (lst) begin
      res.message_done      = 1'b1;
      res.frames_decoded    = st_frames;
      res.message_too_short = short_hdr;
      clear_message();
    end
    has = emit || lst;
  endfunction

  function automatic out_item_t result_word(input logic fv, input logic [28:0] id,
                                            input logic ext, input logic rtr,
                                            input logic [3:0] len, input logic [63:0] data,
                                            input logic done, input logic [7:0] count,
                                            input logic short_msg);
    out_item_t r;
    r.frame_valid       = fv;
    r.frame_id          = id;
    r.frame_extended    = ext;
    r.frame_remote      = rtr;
    r.frame_length      = len;
    r.frame_data        = data;
    r.message_done      = done;
    r.frames_decoded    = count;
    r.message_too_short = short_msg;
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [63:0] e,
                                      input logic [63:0] a);
    if (e !== a) begin
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, e, a);
      mismatches++;
    end
  endfunction

  task automatic add_row(input logic [7:0] b, input logic lst, input logic typed,
                         input out_item_t want);
    dir_rows.push_back({b, lst, typed, want});
  endtask

  // offers one byte from a falling edge and returns at the falling edge after it is taken
  task automatic send_byte(input logic [7:0] b, input logic lst, input logic typed,
                           input out_item_t want);
    if (idle_on && $urandom_range(0, 99) < 18) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    cur_typed = typed;
    cur_want  = want;
    in_valid <= 1'b1;
    in_item  <= {b, lst};
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (decoded_q.size() != 0) @(negedge clk);
    // ignored bytes leave nothing queued, so also let the pipe run idle before going on
    repeat (4) @(negedge clk);
  endtask

  task automatic write_frame_cap(input logic [7:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    frame_cap_cfg = v;
  endtask

  task automatic send_random_message();
    logic [7:0] msg[$];
    logic [7:0] st;
    int kind;
    int nrec;
    int keep;
    kind = $urandom_range(0, 99);
    if (kind < 8) begin
      // noise
      repeat ($urandom_range(1, 12)) msg.push_back(8'($urandom_range(0, 255)));
    end else begin
      nrec = $urandom_range(0, 5);
      msg.push_back(8'($urandom_range(0, 255)));
      if (kind < 14) msg.push_back(8'($urandom_range(0, 255)));
      else if (kind < 80) msg.push_back(8'(nrec));
      else msg.push_back(8'($urandom_range(0, nrec + 1)));
      repeat (nrec) begin
        st = 8'($urandom_range(0, 255));
        msg.push_back(st);
        repeat (st[STATUS_EXT_BIT] ? EXT_ID_BYTES : STD_ID_BYTES)
          msg.push_back(8'($urandom_range(0, 255)));
        if (!st[STATUS_RTR_BIT])
          repeat (clip_len(st)) msg.push_back(8'($urandom_range(0, 255)));
      end
      if ($urandom_range(0, 3) == 0)
        repeat ($urandom_range(1, 3)) msg.push_back(8'($urandom_range(0, 255)));
      // cut some messages short so the last record may be left unfinished
      if ($urandom_range(0, 99) < 15 && msg.size() > 1) begin
        keep = $urandom_range(1, msg.size() - 1);
        while (msg.size() > keep) msg.delete(msg.size() - 1);
      end
    end
    foreach (msg[i]) send_byte(msg[i], i == msg.size() - 1, 1'b0, '0);
  endtask

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("FAILED: results differ");
      $finish;
    end
  end

  // results are compared before the byte taken on the same edge is decoded
  always @(posedge clk) begin
    logic      has;
    out_item_t got;
    out_item_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        results_checked++;
        if (decoded_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual 0x%0h", $time, out_item);
          mismatches++;
        end else begin
          want = decoded_q.pop_front();
          check_field("frame_valid", 64'(want.frame_valid), 64'(out_item.frame_valid));
          check_field("frame_id", 64'(want.frame_id), 64'(out_item.frame_id));
          check_field("frame_extended", 64'(want.frame_extended),
                      64'(out_item.frame_extended));
          check_field("frame_remote", 64'(want.frame_remote), 64'(out_item.frame_remote));
          check_field("frame_length", 64'(want.frame_length), 64'(out_item.frame_length));
          check_field("frame_data", want.frame_data, out_item.frame_data);
          check_field("message_done", 64'(want.message_done), 64'(out_item.message_done));
          check_field("frames_decoded", 64'(want.frames_decoded),
                      64'(out_item.frames_decoded));
          check_field("message_too_short", 64'(want.message_too_short),
                      64'(out_item.message_too_short));
        end
      end
      if (in_valid && !in_stall) begin
        items_taken++;
        live_count++;
        parse_byte(in_item.byte_value, in_item.last_byte, has, got);
        if (cur_typed) begin
          has = 1'b1;
          got = cur_want;
        end
        if (has) decoded_q.push_back(got);
      end
    end
  end

  // result side: random stalls, plus one long hold-off on request
  initial begin
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      out_stall <= idle_on && ($urandom_range(0, 99) < 18);
    end
  end

  initial begin
    int target;
    logic [7:0] cap;
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_item         = '0;
    out_stall       = 1'b0;
    cfg_we          = 1'b0;
    cfg_wdata       = '0;
    cur_typed       = 1'b0;
    cur_want        = '0;
    idle_on         = 1'b1;
    hold_request    = 1'b0;
    mismatches      = 0;
    live_count      = 0;
    items_taken     = 0;
    results_checked = 0;
    cycle_count     = 0;
    frame_cap_cfg   = 8'd255;
    clear_message();

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // one byte only: too short for the header
    add_row(8'h00, 1'b1, 1'b1, result_word(1'b0, 29'h0, 1'b0, 1'b0, 4'h0, 64'h0,
                                           1'b1, 8'h0, 1'b1));
    // record cut off by the last byte, nothing counted
    add_row(8'hFF, 1'b0, 1'b0, '0);
    add_row(8'h05, 1'b0, 1'b0, '0);
    add_row(8'h01, 1'b0, 1'b0, '0);
    add_row(8'h33, 1'b1, 1'b1, result_word(1'b0, 29'h0, 1'b0, 1'b0, 4'h0, 64'h0,
                                           1'b1, 8'h0, 1'b0));
    // three records, then stop at the record count
    add_row(8'hA5, 1'b0, 1'b0, '0);
    add_row(8'h03, 1'b0, 1'b0, '0);
    add_row(8'h02, 1'b0, 1'b0, '0);
    add_row(8'hFF, 1'b0, 1'b0, '0);
    add_row(8'hFF, 1'b0, 1'b0, '0);
    add_row(8'h11, 1'b0, 1'b0, '0);
    add_row(8'h22, 1'b0, 1'b1, result_word(1'b1, 29'h7FF, 1'b0, 1'b0, 4'h2, 64'h2211,
                                           1'b0, 8'h0, 1'b0));
    add_row(8'h38, 1'b0, 1'b0, '0);
    add_row(8'hFF, 1'b0, 1'b0, '0);
    add_row(8'hFF, 1'b0, 1'b0, '0);
    add_row(8'hFF, 1'b0, 1'b0, '0);
    add_row(8'hFF, 1'b0, 1'b1, result_word(1'b1, 29'h1FFFFFFF, 1'b1, 1'b1, 4'h8, 64'h0,
                                           1'b0, 8'h0, 1'b0));
    add_row(8'h00, 1'b0, 1'b0, '0);
    add_row(8'h20, 1'b0, 1'b0, '0);
    add_row(8'h00, 1'b0, 1'b0, '0);
    add_row(8'h0F, 1'b0, 1'b0, '0);
    add_row(8'hAA, 1'b1, 1'b0, '0);
    // remote frame completing on the last byte, shares the summary
    add_row(8'h00, 1'b0, 1'b0, '0);
    add_row(8'h01, 1'b0, 1'b0, '0);
    add_row(8'h10, 1'b0, 1'b0, '0);
    add_row(8'h00, 1'b0, 1'b0, '0);
    add_row(8'h00, 1'b1, 1'b0, '0);

    foreach (dir_rows[i])
      send_byte(dir_rows[i].b, dir_rows[i].lst, dir_rows[i].typed, dir_rows[i].want);
    drain_results();

    live_count = 0;
    for (int p = 0; p < 5; p++) begin
      case (p)
        0: cap = 8'd0;
        1: cap = 8'd1;
        2: cap = 8'd255;
        3: cap = 8'($urandom_range(2, 4));
        default: cap = 8'($urandom_range(0, 255));
      endcase
      write_frame_cap(cap);
      idle_on = (p != 2);
      if (p == 3) hold_request = 1'b1;
      target = (p + 1) * RANDOM_ITEMS / 5;
      while (live_count < target) send_random_message();
      drain_results();
    end

    repeat (10) @(negedge clk);
    $display("Summary: %0d items taken, %0d results checked, %0d field mismatches",
             items_taken, results_checked, mismatches);
    $display("Covered short and cut-off messages, record limits, frame cap 0/1/255/%s",
             "small/random, and a long hold-off on the result side");
    if (mismatches == 0 && decoded_q.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
